// ----- sv/five_tuple_packet_filter_defines.svh -----
// Assertion macros for the five-tuple filter checker
`ifndef FIVE_TUPLE_PACKET_FILTER_DEFINES_SVH
`define FIVE_TUPLE_PACKET_FILTER_DEFINES_SVH

// Clocked check, muted while reset is held
`define FTPF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("five_tuple_packet_filter check failed");

// Clocked check that also holds during reset
`define FTPF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("five_tuple_packet_filter reset check failed");

`endif

// ----- sv/ftpf_pkg.sv -----
// Types and constants of the five-tuple packet filter
`default_nettype none

package ftpf_pkg;

    localparam int RULES_PER_DIRECTION = 32;
    localparam int CNT_W = $clog2(RULES_PER_DIRECTION + 1);

    localparam logic [1:0] ACT_CLASSIFY = 2'd0;
    localparam logic [1:0] ACT_ADD      = 2'd1;
    localparam logic [1:0] ACT_DELETE   = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // wildcard bit positions
    localparam int WC_PROTO   = 0;
    localparam int WC_SRC_IP  = 1;
    localparam int WC_SPORT   = 2;
    localparam int WC_DEST_IP = 3;
    localparam int WC_DPORT   = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic        direction;
        logic [31:0] src_ip;
        logic [31:0] dest_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [4:0]  wildcard_mask;
    } in_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] status;
        logic [5:0] rules_in_direction;
    } out_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [15:0] sport;
        logic [31:0] dest_ip;
        logic [15:0] dport;
        logic [4:0]  wildcard_mask;
    } rule_t;

    typedef struct packed {
        logic cmp_en;
        logic occupied;
        logic need_wc_eq;
        logic load_en;
        logic shift_en;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

endpackage

`default_nettype wire

// ----- sv/ftpf_cell.sv -----
// One rule slot of the filter chain: holds a rule, matches it, loads a new one or shifts from its neighbor
`default_nettype none

module ftpf_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ftpf_pkg::cell_ctrl_t ctrl,
    input  wire ftpf_pkg::rule_t    key,
    input  wire ftpf_pkg::rule_t    load_data,
    input  wire ftpf_pkg::rule_t    neighbor,
    output ftpf_pkg::rule_t         rule,
    output logic                    hit
);

    ftpf_pkg::rule_t rule_reg;
    ftpf_pkg::rule_t rule_next;
    logic            hit_reg;
    logic            hit_next;
    logic            fields_match;
    logic [4:0]      wc;

    assign wc = rule_reg.wildcard_mask;

    always_comb
    begin
        fields_match =
            (wc[ftpf_pkg::WC_PROTO]   || rule_reg.protocol == key.protocol) &&
            (wc[ftpf_pkg::WC_SRC_IP]  || rule_reg.src_ip   == key.src_ip)   &&
            (wc[ftpf_pkg::WC_SPORT]   || rule_reg.sport    == key.sport)    &&
            (wc[ftpf_pkg::WC_DEST_IP] || rule_reg.dest_ip  == key.dest_ip)  &&
            (wc[ftpf_pkg::WC_DPORT]   || rule_reg.dport    == key.dport);
        hit_next = ctrl.cmp_en && ctrl.occupied && fields_match &&
                   (!ctrl.need_wc_eq || wc == key.wildcard_mask);
        rule_next = rule_reg;
        if (ctrl.load_en)
        begin
            rule_next = load_data;
        end
        else if (ctrl.shift_en)
        begin
            rule_next = neighbor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg <= rule_next;
    end

    assign rule = rule_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

// ----- sv/five_tuple_packet_filter.sv -----
// Five-tuple drop-rule filter: two rule tables kept in chains of rule cells
//
// Input channel in_valid/in_ready/in_item carries one transaction per classify, add
// or delete request; output channel out_valid/out_ready/out_item returns exactly one
// result per request, in order.
// Each item goes through the accept cycle, a compare cycle in which every
// cell of the addressed table registers its match bit, and an apply cycle in which
// the result is loaded into the output register and the table is updated (an add
// loads the cell at the tail, a delete shifts every cell from the first match on
// by one place toward the head). The result is registered in the apply cycle, and
// no new item is taken until the previous one has left the apply cycle.
// A new item is accepted while the previous result still waits in the output
// register. If the receiver stalls, the apply cycle waits until the output
// register frees up, and the input channel holds off until then.
// Reset empties both tables (rule counts go to zero) and drops any pending result;
// no clearing pass is needed, since only cells below the count are ever matched.
`default_nettype none

module five_tuple_packet_filter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ftpf_pkg::in_t  in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ftpf_pkg::out_t      out_item
);

    localparam int N = ftpf_pkg::RULES_PER_DIRECTION;
    localparam int CW = ftpf_pkg::CNT_W;

    ftpf_pkg::state_t state_reg;
    ftpf_pkg::state_t state_next;
    ftpf_pkg::in_t    item_reg;
    ftpf_pkg::out_t   out_reg;
    ftpf_pkg::out_t   out_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CW-1:0]    count_reg [2];
    logic [CW-1:0]    count_next [2];

    logic             accept;
    logic             go;
    logic [CW-1:0]    cur_count;
    logic [CW-1:0]    new_count;
    logic             tbl_full;
    logic             is_classify;
    logic             is_add;
    logic             is_delete;
    logic             proto_ok;
    logic [N-1:0]     sel_hit;
    logic [N-1:0]     pre_hit;
    logic             any_hit;

    ftpf_pkg::rule_t  key;
    ftpf_pkg::rule_t  load_data;
    ftpf_pkg::rule_t  cell_rule [2][N];
    logic [N-1:0]     hit_vec [2];

    assign accept      = in_valid && in_ready;
    assign cur_count   = count_reg[item_reg.direction];
    assign tbl_full    = cur_count >= CW'(N);
    assign is_classify = item_reg.action == ftpf_pkg::ACT_CLASSIFY;
    assign is_add      = item_reg.action == ftpf_pkg::ACT_ADD;
    assign is_delete   = item_reg.action == ftpf_pkg::ACT_DELETE;
    assign proto_ok    = item_reg.protocol == ftpf_pkg::PROTO_TCP ||
                         item_reg.protocol == ftpf_pkg::PROTO_UDP;
    assign sel_hit     = item_reg.direction ? hit_vec[1] : hit_vec[0];
    assign any_hit     = |sel_hit;

    always_comb
    begin
        key.protocol      = item_reg.protocol;
        key.src_ip        = item_reg.src_ip;
        key.sport         = item_reg.sport;
        key.dest_ip       = item_reg.dest_ip;
        key.dport         = item_reg.dport;
        key.wildcard_mask = item_reg.wildcard_mask;

        // stored rules keep zero in unstated fields
        load_data = key;
        if (item_reg.wildcard_mask[ftpf_pkg::WC_PROTO])
        begin
            load_data.protocol = '0;
        end
        if (item_reg.wildcard_mask[ftpf_pkg::WC_SRC_IP])
        begin
            load_data.src_ip = '0;
        end
        if (item_reg.wildcard_mask[ftpf_pkg::WC_SPORT])
        begin
            load_data.sport = '0;
        end
        if (item_reg.wildcard_mask[ftpf_pkg::WC_DEST_IP])
        begin
            load_data.dest_ip = '0;
        end
        if (item_reg.wildcard_mask[ftpf_pkg::WC_DPORT])
        begin
            load_data.dport = '0;
        end
    end

    // hit at or before each place: that cell and all later ones move up on delete
    for (genvar j = 0; j < N; j++)
    begin : g_pre
        assign pre_hit[j] = |sel_hit[j:0];
    end

    for (genvar d = 0; d < 2; d++)
    begin : g_dir
        for (genvar j = 0; j < N; j++)
        begin : g_cell
            ftpf_pkg::cell_ctrl_t ctrl;
            ftpf_pkg::rule_t      nbr;
            logic                 in_dir;

            assign in_dir = item_reg.direction == 1'(d);

            always_comb
            begin
                ctrl.cmp_en     = state_reg == ftpf_pkg::ST_CMP && in_dir;
                ctrl.occupied   = CW'(j) < count_reg[d];
                ctrl.need_wc_eq = is_delete;
                ctrl.load_en    = go && in_dir && is_add && !tbl_full &&
                                  CW'(j) == count_reg[d];
                ctrl.shift_en   = go && in_dir && is_delete && pre_hit[j];
            end

            if (j == N - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_rule[d][j+1];
            end

            ftpf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .key       (key),
                .load_data (load_data),
                .neighbor  (nbr),
                .rule      (cell_rule[d][j]),
                .hit       (hit_vec[d][j])
            );
        end
    end

    // sequencer and result formation
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        go             = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        new_count      = cur_count;
        count_next[0]  = count_reg[0];
        count_next[1]  = count_reg[1];

        case (state_reg)
            ftpf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ftpf_pkg::ST_CMP;
                end
            end
            ftpf_pkg::ST_CMP:
            begin
                state_next = ftpf_pkg::ST_APPLY;
            end
            ftpf_pkg::ST_APPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    go = 1'b1;
                    state_next = ftpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftpf_pkg::ST_IDLE;
            end
        endcase

        if (go)
        begin
            out_next.drop   = 1'b0;
            out_next.status = ftpf_pkg::STATUS_DONE;
            if (is_classify)
            begin
                out_next.drop = proto_ok && any_hit;
            end
            else if (is_add)
            begin
                if (tbl_full)
                begin
                    out_next.status = ftpf_pkg::STATUS_FULL;
                end
                else
                begin
                    new_count = cur_count + CW'(1);
                end
            end
            else if (is_delete)
            begin
                if (!any_hit)
                begin
                    out_next.status = ftpf_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    new_count = cur_count - CW'(1);
                end
            end
            out_next.rules_in_direction = 6'(new_count);
            count_next[item_reg.direction] = new_count;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftpf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg[0]  <= count_next[0];
            count_reg[1]  <= count_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ----- sv/ftpf_checker.sv -----
// Port-level checks of the five-tuple filter, bound to the top level
`default_nettype none

`include "five_tuple_packet_filter_defines.svh"

module ftpf_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  wire ftpf_pkg::in_t  in_item,
    input  wire logic           out_valid,
    input  wire logic           out_ready,
    input  wire ftpf_pkg::out_t out_item
);

    // hold a stalled result
    `FTPF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))

    // one item at a time: no accept right after an accept
    `FTPF_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready)

    // only classify can drop, and classify always reports done
    `FTPF_ASSERT(a_drop_done, out_valid && out_item.drop |-> out_item.status == ftpf_pkg::STATUS_DONE)

    // a full report leaves the table at capacity
    `FTPF_ASSERT(a_full_count, out_valid && out_item.status == ftpf_pkg::STATUS_FULL |-> out_item.rules_in_direction == 6'(ftpf_pkg::RULES_PER_DIRECTION))

    // no result during reset; valid may still be unknown before the first reset edge
    `FTPF_ASSERT_RST(a_reset_quiet, !rst_n |-> out_valid !== 1'b1)

endmodule

bind five_tuple_packet_filter ftpf_checker u_ftpf_checker (.*);

`default_nettype wire
